FILE: hw/rtl/shs_pkg.sv
`timescale 1ns / 1ps

package shs_pkg;

  // event codes carried in the request action field
  localparam logic [1:0] ACT_SPAWN = 2'd0;
  localparam logic [1:0] ACT_EXIT  = 2'd1;
  localparam logic [1:0] ACT_PONG  = 2'd2;
  localparam logic [1:0] ACT_TICK  = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_EVENT = 2'd0;
  localparam logic [1:0] KIND_PING  = 2'd1;
  localparam logic [1:0] KIND_KILL  = 2'd2;

  // event outcomes
  localparam logic [2:0] OUT_OK           = 3'd0;
  localparam logic [2:0] OUT_SPAWN_FAIL   = 3'd1;
  localparam logic [2:0] OUT_COMPLETED    = 3'd2;
  localparam logic [2:0] OUT_HEALED       = 3'd3;
  localparam logic [2:0] OUT_FLAP         = 3'd4;
  localparam logic [2:0] OUT_RESPAWN_FAIL = 3'd5;

  // service status codes
  localparam logic [2:0] ST_BOOT    = 3'd0;
  localparam logic [2:0] ST_UP      = 3'd1;
  localparam logic [2:0] ST_PENDING = 3'd2;
  localparam logic [2:0] ST_DEAD    = 3'd3;
  localparam logic [2:0] ST_FAILED  = 3'd4;

  // configuration register indexes
  localparam logic [2:0] CFG_SERVICE_COUNT  = 3'd0;
  localparam logic [2:0] CFG_PING_PERIOD    = 3'd1;
  localparam logic [2:0] CFG_PING_DEADLINE  = 3'd2;
  localparam logic [2:0] CFG_RESTART_WINDOW = 3'd3;
  localparam logic [2:0] CFG_RESTART_BUDGET = 3'd4;
  localparam logic [2:0] CFG_RESTART_BACKOFF = 3'd5;
  localparam logic [2:0] CFG_PING_KIND_MASK = 3'd6;

  localparam int CFG_DATA_W = 20;

  typedef struct packed {
    logic [1:0]  action;
    logic [1:0]  service;
    logic [47:0] now_ms;
    logic        exit_clean;
    logic        spawn_ok;
    logic [3:0]  send_ok_mask;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  target;
    logic [2:0]  outcome;
    logic [2:0]  service_state;
    logic        probe_kind;
    logic [15:0] restart_total;
    logic        last;
  } out_rsp_t;

  typedef struct packed {
    logic [2:0]  service_count;
    logic [19:0] probe_gap;
    logic [19:0] probe_wait;
    logic [19:0] flap_span;
    logic [3:0]  flap_limit;
    logic [15:0] respawn_delay;
    logic [3:0]  ping_kind_mask;
  } cfg_t;

  // per-service mask bit, services past the fourth read zero
  function automatic logic mask_bit(input logic [3:0] m, input logic [3:0] i);
    return (i < 4'd4) ? m[i[1:0]] : 1'b0;
  endfunction

endpackage

FILE: hw/rtl/service_health_supervisor.sv
`timescale 1ns / 1ps

// Service health supervisor. A request is taken when start is high and busy is low;
// busy then stays high until the final result of that request is being put out: it
// falls in the very cycle that carries that final result, and a new request may be
// taken in that cycle. Results leave at most one per cycle on out_rsp, marked by a one-cycle
// out_valid strobe, and the final one of a request carries last; the receiver cannot
// hold them off, so it must take every strobed cycle. The per-service state lives in
// a table with a registered read, visited one entry per cycle: a request passes the
// event read-modify-write, the read of the first entry, the sweep of n entries (n
// being the swept service count, service_count clamped to MAX_SERVICES) and a flush;
// a tick or an out-of-table event skips the first. Each entry reads as its reset value
// until first written, so no clearing pass follows reset. Configuration is
// written through cfg_we/cfg_idx/cfg_wdata and should only change while idle.
module service_health_supervisor
  import shs_pkg::*;
#(
  parameter int MAX_SERVICES = 4,
  parameter int TIME_BITS = 48
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_req_t               in_req,
  output logic                  out_valid,
  output out_rsp_t              out_rsp,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W = (MAX_SERVICES > 1) ? $clog2(MAX_SERVICES) : 1;
  localparam int CNT_W = $clog2(MAX_SERVICES + 1);
  localparam int ENT_W = 3 + 3 * TIME_BITS + 16 + 5;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EVT  = 5'b00010,
    S_SRD  = 5'b00100,
    S_SWP  = 5'b01000,
    S_FLS  = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  in_req_t          req_r, req_nxt;
  cfg_t             cfg_r, cfg_nxt;
  logic [IDX_W-1:0] sw_idx_r, sw_idx_nxt;
  logic             pend_valid_r, pend_valid_nxt;
  out_rsp_t         pend_r, pend_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_rsp_t         out_rsp_r, out_rsp_nxt;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [ENT_W-1:0] rd_data;
  logic             tbl_wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [ENT_W-1:0] wr_entry;
  logic             ex_wr_en;
  logic             res_valid;
  out_rsp_t         res;
  logic             in_event;
  logic [CNT_W-1:0] count_eff;
  logic             sw_last;
  logic             push;

  // swept services, clamped to the table size
  assign count_eff = (32'(cfg_r.service_count) > MAX_SERVICES) ?
                     CNT_W'(MAX_SERVICES) : CNT_W'(cfg_r.service_count);
  assign sw_last   = (CNT_W'(sw_idx_r) + CNT_W'(1)) == count_eff;
  assign in_event  = (in_req.action != ACT_TICK) && (32'(in_req.service) < MAX_SERVICES);

  shs_table #(
    .DEPTH (MAX_SERVICES),
    .IDX_W (IDX_W),
    .ENT_W (ENT_W)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (tbl_wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry)
  );

  shs_exec #(
    .TIME_BITS    (TIME_BITS),
    .IDX_W        (IDX_W),
    .ENT_W        (ENT_W)
  ) u_exec (
    .sweep     (state_r == S_SWP),
    .req       (req_r),
    .cfg       (cfg_r),
    .idx       (sw_idx_r),
    .rd_entry  (rd_data),
    .wr_entry  (wr_entry),
    .wr_en     (ex_wr_en),
    .res_valid (res_valid),
    .res       (res)
  );

  // configuration writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_SERVICE_COUNT:   cfg_nxt.service_count  = cfg_wdata[2:0];
        CFG_PING_PERIOD:     cfg_nxt.probe_gap      = cfg_wdata[19:0];
        CFG_PING_DEADLINE:   cfg_nxt.probe_wait     = cfg_wdata[19:0];
        CFG_RESTART_WINDOW:  cfg_nxt.flap_span      = cfg_wdata[19:0];
        CFG_RESTART_BUDGET:  cfg_nxt.flap_limit     = cfg_wdata[3:0];
        CFG_RESTART_BACKOFF: cfg_nxt.respawn_delay  = cfg_wdata[15:0];
        CFG_PING_KIND_MASK:  cfg_nxt.ping_kind_mask = cfg_wdata[3:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  // sequencer: event read-modify-write, then one table entry per cycle
  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    sw_idx_nxt     = sw_idx_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = 1'b0;
    out_rsp_nxt    = out_rsp_r;
    rd_en          = 1'b0;
    rd_addr        = sw_idx_r;
    tbl_wr_en      = 1'b0;
    wr_addr        = sw_idx_r;
    push           = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt   = in_req;
          rd_en     = 1'b1;
          rd_addr   = IDX_W'(in_req.service);
          state_nxt = in_event ? S_EVT : S_SRD;
        end
      end
      S_EVT: begin
        tbl_wr_en = ex_wr_en;
        wr_addr   = IDX_W'(req_r.service);
        push      = res_valid;
        state_nxt = S_SRD;
      end
      S_SRD: begin
        // read of the first entry follows the event write
        rd_en      = 1'b1;
        rd_addr    = '0;
        sw_idx_nxt = '0;
        state_nxt  = (count_eff == '0) ? S_FLS : S_SWP;
      end
      S_SWP: begin
        tbl_wr_en = ex_wr_en;
        wr_addr   = sw_idx_r;
        push      = res_valid;
        if (sw_last) begin
          state_nxt = S_FLS;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = sw_idx_r + IDX_W'(1);
          sw_idx_nxt = sw_idx_r + IDX_W'(1);
        end
      end
      S_FLS: begin
        // the held result is the final one of this request
        if (pend_valid_r) begin
          out_valid_nxt      = 1'b1;
          out_rsp_nxt        = pend_r;
          out_rsp_nxt.last   = 1'b1;
        end
        pend_valid_nxt = 1'b0;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // hold one result back so the last one can be marked
    if (push) begin
      if (pend_valid_r) begin
        out_valid_nxt    = 1'b1;
        out_rsp_nxt      = pend_r;
        out_rsp_nxt.last = 1'b0;
      end
      pend_nxt       = res;
      pend_valid_nxt = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      pend_valid_r  <= 1'b0;
      out_valid_r   <= 1'b0;
      sw_idx_r      <= '0;
      cfg_r.service_count  <= 3'd3;
      cfg_r.probe_gap      <= 20'd2000;
      cfg_r.probe_wait     <= 20'd1500;
      cfg_r.flap_span      <= 20'd30000;
      cfg_r.flap_limit     <= 4'd5;
      cfg_r.respawn_delay  <= 16'd50;
      cfg_r.ping_kind_mask <= 4'd1;
    end else begin
      state_r      <= state_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      sw_idx_r     <= sw_idx_nxt;
      cfg_r        <= cfg_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    pend_r    <= pend_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // no result is held over while waiting for a request
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_valid_r)
    else $error("held result left over at idle");

  // the final result closes the request
  a_last_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.last) |=> !out_valid)
    else $error("result after the final one");

  // results only come out of a request in progress
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a request");

  // a table entry is never read and written in the same cycle
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && tbl_wr_en) |-> (rd_addr != wr_addr))
    else $error("read and write of the same table entry");

endmodule

FILE: hw/rtl/shs_table.sv
`timescale 1ns / 1ps

module shs_table #(
  parameter int DEPTH = 4,
  parameter int IDX_W = 2,
  parameter int ENT_W = 168
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [ENT_W-1:0] rd_data,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [ENT_W-1:0] wr_data
);

  logic [ENT_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [ENT_W-1:0] rd_raw_r;
  logic             rd_vld_r;

  // entry storage, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_raw_r <= mem[rd_addr];
    end
  end

  // written flags, an unwritten entry reads as the all-zero reset entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_raw_r : '0;

endmodule

FILE: hw/rtl/shs_exec.sv
`timescale 1ns / 1ps

module shs_exec
  import shs_pkg::*;
#(
  parameter int TIME_BITS = 48,
  parameter int IDX_W = 2,
  parameter int ENT_W = 168
) (
  input  logic             sweep,
  input  in_req_t          req,
  input  cfg_t             cfg,
  input  logic [IDX_W-1:0] idx,
  input  logic [ENT_W-1:0] rd_entry,
  output logic [ENT_W-1:0] wr_entry,
  output logic             wr_en,
  output logic             res_valid,
  output out_rsp_t         res
);

  typedef struct packed {
    logic [2:0]           status;
    logic [TIME_BITS-1:0] last_good;
    logic [TIME_BITS-1:0] ping_sent;
    logic [15:0]          restart_cnt;
    logic [4:0]           win_cnt;
    logic [TIME_BITS-1:0] win_begin;
  } entry_t;

  entry_t               cur;
  entry_t               ev_ent;
  entry_t               sw_ent;
  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] win_diff;
  logic [TIME_BITS-1:0] wb0;
  logic [4:0]           wc0;
  logic [4:0]           wc1;
  logic [2:0]           ev_outcome;
  logic [TIME_BITS-1:0] ping_age;
  logic [TIME_BITS-1:0] idle_age;
  logic                 sw_hit;
  logic [1:0]           sw_kind;
  logic                 sw_probe;
  logic                 sw_wr;

  assign cur = entry_t'(rd_entry);
  assign now = TIME_BITS'(req.now_ms);

  // event update for the addressed service
  always_comb begin
    ev_ent     = cur;
    ev_outcome = OUT_OK;
    wb0        = (cur.win_begin == '0) ? now : cur.win_begin;
    win_diff   = now - wb0;
    wc0        = cur.win_cnt;
    wc1        = cur.win_cnt;
    case (req.action)
      ACT_SPAWN: begin
        ev_ent.win_cnt     = '0;
        ev_ent.win_begin   = '0;
        ev_ent.restart_cnt = '0;
        ev_ent.status      = ST_BOOT;
        if (req.spawn_ok) begin
          ev_ent.status    = ST_UP;
          ev_ent.last_good = now;
          ev_ent.ping_sent = '0;
        end else begin
          ev_outcome = OUT_SPAWN_FAIL;
        end
      end
      ACT_EXIT: begin
        ev_ent.status = ST_DEAD;
        if (req.exit_clean) begin
          ev_outcome = OUT_COMPLETED;
        end else begin
          // flap window: reopen when the current one has run out
          if (64'(win_diff) > 64'(cfg.flap_span)) begin
            ev_ent.win_begin = now;
            wc0              = '0;
          end else begin
            ev_ent.win_begin = wb0;
          end
          wc1            = (wc0 != 5'd31) ? wc0 + 5'd1 : wc0;
          ev_ent.win_cnt = wc1;
          if (wc1 > {1'b0, cfg.flap_limit}) begin
            ev_ent.status = ST_FAILED;
            ev_outcome    = OUT_FLAP;
          end else begin
            if (cur.restart_cnt != 16'hFFFF) begin
              ev_ent.restart_cnt = cur.restart_cnt + 16'd1;
            end
            if (req.spawn_ok) begin
              ev_ent.status    = ST_UP;
              ev_ent.last_good = TIME_BITS'(64'(now) + 64'(cfg.respawn_delay));
              ev_ent.ping_sent = '0;
              ev_outcome       = OUT_HEALED;
            end else begin
              ev_ent.status = ST_FAILED;
              ev_outcome    = OUT_RESPAWN_FAIL;
            end
          end
        end
      end
      default: begin
        // pong
        ev_ent.status    = ST_UP;
        ev_ent.last_good = now;
        ev_ent.ping_sent = '0;
      end
    endcase
  end

  // sweep check of one service
  always_comb begin
    sw_ent   = cur;
    sw_hit   = 1'b0;
    sw_wr    = 1'b0;
    sw_kind  = KIND_PING;
    sw_probe = 1'b0;
    ping_age = now - cur.ping_sent;
    idle_age = now - cur.last_good;
    case (cur.status)
      ST_PENDING: begin
        if (64'(ping_age) > 64'(cfg.probe_wait)) begin
          sw_hit  = 1'b1;
          sw_kind = KIND_KILL;
        end
      end
      ST_UP, ST_DEAD: begin
        if (64'(idle_age) > 64'(cfg.probe_gap)) begin
          sw_hit   = 1'b1;
          sw_probe = mask_bit(cfg.ping_kind_mask, 4'(idx));
          if (mask_bit(req.send_ok_mask, 4'(idx))) begin
            sw_wr            = 1'b1;
            sw_ent.status    = ST_PENDING;
            sw_ent.ping_sent = now;
          end
        end
      end
      default: begin
        sw_hit = 1'b0;
      end
    endcase
  end

  // result and write-back selection
  always_comb begin
    res.last = 1'b0;
    if (sweep) begin
      wr_entry          = ENT_W'(sw_ent);
      wr_en             = sw_wr;
      res_valid         = sw_hit;
      res.kind          = sw_kind;
      res.target        = 2'(idx);
      res.outcome       = OUT_OK;
      res.service_state = sw_ent.status;
      res.probe_kind    = sw_probe;
      res.restart_total = sw_ent.restart_cnt;
    end else begin
      wr_entry          = ENT_W'(ev_ent);
      wr_en             = 1'b1;
      res_valid         = 1'b1;
      res.kind          = KIND_EVENT;
      res.target        = req.service;
      res.outcome       = ev_outcome;
      res.service_state = ev_ent.status;
      res.probe_kind    = 1'b0;
      res.restart_total = ev_ent.restart_cnt;
    end
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import shs_pkg::*;

  localparam int NSVC = 4;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 12;

  typedef struct packed {
    in_req_t req;
    logic    drain_first;
  } request_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_req_t               in_req;
  logic                  out_valid;
  out_rsp_t              out_rsp;
  logic                  cfg_we;
  logic [2:0]            cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  service_health_supervisor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // requests waiting to be offered, reports the block still owes
  request_t request_q[$];
  out_rsp_t report_q[$];

  // shadow copy of the service table and registers
  cfg_t        sh_cfg;
  logic [2:0]  sh_status    [NSVC];
  logic [47:0] sh_last_good [NSVC];
  logic [47:0] sh_ping_sent [NSVC];
  logic [15:0] sh_restarts  [NSVC];
  logic [4:0]  sh_win_cnt   [NSVC];
  logic [47:0] sh_win_begin [NSVC];

  int          err_cnt = 0;
  int          idle_pct = 17;
  logic        offer_taken = 1'b0;
  logic [47:0] sim_ms = '0;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void reset_table();
    sh_cfg.service_count  = 3'd3;
    sh_cfg.probe_gap      = 20'd2000;
    sh_cfg.probe_wait     = 20'd1500;
    sh_cfg.flap_span      = 20'd30000;
    sh_cfg.flap_limit     = 4'd5;
    sh_cfg.respawn_delay  = 16'd50;
    sh_cfg.ping_kind_mask = 4'd1;
    for (int i = 0; i < NSVC; i++) begin
      sh_status[i]    = ST_BOOT;
      sh_last_good[i] = '0;
      sh_ping_sent[i] = '0;
      sh_restarts[i]  = '0;
      sh_win_cnt[i]   = '0;
      sh_win_begin[i] = '0;
    end
  endfunction

  function automatic void shadow_write(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_SERVICE_COUNT:   sh_cfg.service_count  = val[2:0];
      CFG_PING_PERIOD:     sh_cfg.probe_gap      = val[19:0];
      CFG_PING_DEADLINE:   sh_cfg.probe_wait     = val[19:0];
      CFG_RESTART_WINDOW:  sh_cfg.flap_span      = val[19:0];
      CFG_RESTART_BUDGET:  sh_cfg.flap_limit     = val[3:0];
      CFG_RESTART_BACKOFF: sh_cfg.respawn_delay  = val[15:0];
      CFG_PING_KIND_MASK:  sh_cfg.ping_kind_mask = val[3:0];
      default: ;
    endcase
  endfunction

  function automatic void owe_report(input logic [1:0] kind, input logic [1:0] tgt,
                                     input logic [2:0] outcome, input logic probe);
    out_rsp_t r;
    r.kind          = kind;
    r.target        = tgt;
    r.outcome       = outcome;
    r.service_state = sh_status[tgt];
    r.probe_kind    = probe;
    r.restart_total = sh_restarts[tgt];
    r.last          = 1'b0;
    report_q.push_back(r);
  endfunction

  // event handling then the health sweep, as the block should do it
  function automatic void supervise_request(input in_req_t r);
    logic [1:0]  s;
    logic [47:0] now;
    logic [47:0] age;
    logic [2:0]  outcome;
    int          base;
    int          count;
    out_rsp_t    tail;
    s = r.service;
    now = r.now_ms;
    outcome = OUT_OK;
    base = report_q.size();
    if (r.action != ACT_TICK) begin
      case (r.action)
        ACT_SPAWN: begin
          sh_win_cnt[s] = '0;
          sh_win_begin[s] = '0;
          sh_restarts[s] = '0;
          sh_status[s] = ST_BOOT;
          if (r.spawn_ok) begin
            sh_status[s] = ST_UP;
            sh_last_good[s] = now;
            sh_ping_sent[s] = '0;
          end else begin
            outcome = OUT_SPAWN_FAIL;
          end
        end
        ACT_EXIT: begin
          sh_status[s] = ST_DEAD;
          if (r.exit_clean) begin
            outcome = OUT_COMPLETED;
          end else begin
            // flap window: zero start means not yet opened
            if (sh_win_begin[s] == '0) sh_win_begin[s] = now;
            age = now - sh_win_begin[s];
            if (age > 48'(sh_cfg.flap_span)) begin
              sh_win_begin[s] = now;
              sh_win_cnt[s] = '0;
            end
            if (sh_win_cnt[s] < 5'd31) sh_win_cnt[s] = sh_win_cnt[s] + 5'd1;
            if (sh_win_cnt[s] > 5'(sh_cfg.flap_limit)) begin
              sh_status[s] = ST_FAILED;
              outcome = OUT_FLAP;
            end else begin
              if (sh_restarts[s] != 16'hFFFF) sh_restarts[s] = sh_restarts[s] + 16'd1;
              if (r.spawn_ok) begin
                sh_status[s] = ST_UP;
                sh_last_good[s] = now + 48'(sh_cfg.respawn_delay);
                sh_ping_sent[s] = '0;
                outcome = OUT_HEALED;
              end else begin
                sh_status[s] = ST_FAILED;
                outcome = OUT_RESPAWN_FAIL;
              end
            end
          end
        end
        default: begin
          sh_status[s] = ST_UP;
          sh_last_good[s] = now;
          sh_ping_sent[s] = '0;
        end
      endcase
      owe_report(KIND_EVENT, s, outcome, 1'b0);
    end

    // sweep, count clamped to the table size
    count = (sh_cfg.service_count > 3'(NSVC)) ? NSVC : int'(sh_cfg.service_count);
    for (int i = 0; i < count; i++) begin
      if (sh_status[i] == ST_PENDING) begin
        age = now - sh_ping_sent[i];
        if (age > 48'(sh_cfg.probe_wait)) owe_report(KIND_KILL, 2'(i), OUT_OK, 1'b0);
      end else if (sh_status[i] == ST_UP || sh_status[i] == ST_DEAD) begin
        age = now - sh_last_good[i];
        if (age > 48'(sh_cfg.probe_gap)) begin
          if (r.send_ok_mask[i]) begin
            sh_status[i] = ST_PENDING;
            sh_ping_sent[i] = now;
          end
          owe_report(KIND_PING, 2'(i), OUT_OK, sh_cfg.ping_kind_mask[i]);
        end
      end
    end

    if (report_q.size() > base) begin
      tail = report_q[report_q.size() - 1];
      tail.last = 1'b1;
      report_q[report_q.size() - 1] = tail;
    end
  endfunction

  // result check, then request accept
  always @(posedge clk) begin : watch_outputs
    out_rsp_t want;
    if (!rst_n) begin
      offer_taken <= 1'b0;
    end else begin
      if (out_valid) begin
        if (report_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("unexpected result %h", out_rsp);
        end else begin
          want = report_q.pop_front();
          if (want.kind !== out_rsp.kind || want.target !== out_rsp.target ||
              want.outcome !== out_rsp.outcome ||
              want.service_state !== out_rsp.service_state ||
              want.probe_kind !== out_rsp.probe_kind ||
              want.restart_total !== out_rsp.restart_total || want.last !== out_rsp.last) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("mismatch kind/tgt/outcome/state/probe/restarts/last");
              $display("  expected %0d %0d %0d %0d %0d %0d %0d",
                       want.kind, want.target, want.outcome, want.service_state,
                       want.probe_kind, want.restart_total, want.last);
              $display("  got      %0d %0d %0d %0d %0d %0d %0d",
                       out_rsp.kind, out_rsp.target, out_rsp.outcome, out_rsp.service_state,
                       out_rsp.probe_kind, out_rsp.restart_total, out_rsp.last);
            end
          end
        end
      end
      if (start && !busy) begin
        supervise_request(in_req);
        void'(request_q.pop_front());
        offer_taken <= 1'b1;
      end else begin
        offer_taken <= 1'b0;
      end
    end
  end

  // request driver, holds an offer until it is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || offer_taken) begin
      if (request_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
        if (request_q[0].drain_first && (report_q.size() > 0 || busy)) begin
          start <= 1'b0;
        end else begin
          start <= 1'b1;
          in_req <= request_q[0].req;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  function automatic void queue_request(input logic [1:0] act, input logic [1:0] svc,
                                        input logic clean, input logic ok,
                                        input logic [3:0] mask);
    request_t p;
    p.req.action       = act;
    p.req.service      = svc;
    p.req.now_ms       = sim_ms;
    p.req.exit_clean   = clean;
    p.req.spawn_ok     = ok;
    p.req.send_ok_mask = mask;
    p.drain_first      = ($urandom_range(99) < 2);
    request_q.push_back(p);
  endfunction

  // mostly forward steps, now and then a jump anywhere in the time range
  function automatic void advance_clock(input int step);
    if ($urandom_range(99) < 3) sim_ms = {16'($urandom), 32'($urandom)};
    else sim_ms = sim_ms + 48'($urandom_range(step));
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    shadow_write(idx, val);
  endtask

  task automatic write_all(input logic [2:0] cnt, input logic [19:0] period,
                           input logic [19:0] deadline, input logic [19:0] window,
                           input logic [3:0] budget, input logic [15:0] backoff,
                           input logic [3:0] kinds);
    write_reg(CFG_SERVICE_COUNT, 20'(cnt));
    write_reg(CFG_PING_PERIOD, period);
    write_reg(CFG_PING_DEADLINE, deadline);
    write_reg(CFG_RESTART_WINDOW, window);
    write_reg(CFG_RESTART_BUDGET, 20'(budget));
    write_reg(CFG_RESTART_BACKOFF, 20'(backoff));
    write_reg(CFG_PING_KIND_MASK, 20'(kinds));
  endtask

  task automatic wait_drain();
    while (request_q.size() > 0 || report_q.size() > 0 || start || busy) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // random traffic: flap bursts, service lifecycles and loose noise
  task automatic random_phase(input int n_items, input int step);
    int         made;
    int         pick;
    int         len;
    logic [1:0] svc;
    made = 0;
    while (made < n_items) begin
      pick = $urandom_range(99);
      svc = 2'($urandom_range(3));
      if (pick < 15) begin
        len = ($urandom_range(3) == 0) ? $urandom_range(20, 36) : $urandom_range(2, 8);
        for (int k = 0; k < len; k++) begin
          sim_ms = sim_ms + 48'($urandom_range(50));
          queue_request(ACT_EXIT, svc, 1'b0, $urandom_range(9) != 0, 4'($urandom));
        end
        made += len;
      end else if (pick < 60) begin
        advance_clock(step);
        queue_request(ACT_SPAWN, svc, 1'($urandom), $urandom_range(9) != 0, 4'($urandom));
        len = $urandom_range(3, 8);
        for (int k = 0; k < len; k++) begin
          advance_clock(step);
          pick = $urandom_range(99);
          if (pick < 40)
            queue_request(ACT_PONG, svc, 1'($urandom), 1'($urandom), 4'($urandom));
          else if (pick < 85)
            queue_request(ACT_TICK, 2'($urandom), 1'($urandom), 1'($urandom), 4'($urandom));
          else
            queue_request(ACT_EXIT, svc, 1'($urandom), $urandom_range(3) != 0, 4'($urandom));
        end
        made += len + 1;
      end else begin
        advance_clock(step);
        queue_request(2'($urandom), svc, 1'($urandom), 1'($urandom), 4'($urandom));
        made++;
      end
    end
    // one forced pause until the block has caught up
    request_q[request_q.size() / 2].drain_first = 1'b1;
  endtask

  // watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_req = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    reset_table();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part under reset register values
    sim_ms = 48'd0;
    queue_request(ACT_TICK, 2'd0, 1'b0, 1'b0, 4'hF);
    queue_request(ACT_SPAWN, 2'd0, 1'b0, 1'b1, 4'h0);
    sim_ms = 48'd10;
    queue_request(ACT_SPAWN, 2'd1, 1'b0, 1'b0, 4'h0);
    sim_ms = 48'd20;
    queue_request(ACT_SPAWN, 2'd2, 1'b0, 1'b1, 4'h0);
    sim_ms = 48'd30;
    queue_request(ACT_SPAWN, 2'd3, 1'b0, 1'b1, 4'h0);
    // unclean exit at time zero leaves the flap window unopened
    sim_ms = 48'd0;
    queue_request(ACT_EXIT, 2'd0, 1'b0, 1'b1, 4'h0);
    sim_ms = 48'd100;
    queue_request(ACT_EXIT, 2'd0, 1'b1, 1'b0, 4'h0);
    // pings that cannot be sent, then pings that go out, then kills
    sim_ms = 48'd2200;
    queue_request(ACT_TICK, 2'd0, 1'b0, 1'b0, 4'h0);
    sim_ms = 48'd2300;
    queue_request(ACT_TICK, 2'd0, 1'b0, 1'b0, 4'hF);
    sim_ms = 48'd4000;
    queue_request(ACT_TICK, 2'd0, 1'b0, 1'b0, 4'hF);
    queue_request(ACT_PONG, 2'd0, 1'b0, 1'b0, 4'h0);
    sim_ms = 48'd4100;
    queue_request(ACT_PONG, 2'd3, 1'b0, 1'b0, 4'h0);
    sim_ms = 48'd4200;
    queue_request(ACT_EXIT, 2'd3, 1'b0, 1'b0, 4'h0);
    // restarts of a service still in boot until the budget runs out
    for (int k = 0; k < 6; k++) begin
      sim_ms = 48'd4300 + 48'(k * 100);
      queue_request(ACT_EXIT, 2'd1, 1'b0, 1'b1, 4'h0);
    end
    sim_ms = 48'd4900;
    queue_request(ACT_PONG, 2'd1, 1'b0, 1'b0, 4'h0);
    // time wraparound
    sim_ms = '1;
    queue_request(ACT_TICK, 2'd0, 1'b0, 1'b0, 4'hF);
    queue_request(ACT_PONG, 2'd2, 1'b1, 1'b1, 4'hF);
    sim_ms = 48'd5;
    queue_request(ACT_TICK, 2'd0, 1'b0, 1'b0, 4'hF);
    sim_ms = 48'd10;
    queue_request(ACT_EXIT, 2'd3, 1'b0, 1'b1, 4'h0);
    sim_ms = 48'h8000_0000_0000;
    queue_request(ACT_SPAWN, 2'd2, 1'b0, 1'b0, 4'h0);
    wait_drain();

    write_all(3'd4, 20'd300, 20'd200, 20'd5000, 4'd3, 16'd100, 4'b1010);
    random_phase(150, 250);
    wait_drain();

    // minimum values, count above the table size
    write_all(3'd7, 20'd0, 20'd0, 20'd0, 4'd0, 16'd0, 4'b0000);
    random_phase(60, 100);
    wait_drain();

    // maximum values
    idle_pct = 71;
    write_all(3'd4, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 4'd15, 16'hFFFF, 4'b1111);
    random_phase(60, 400000);
    wait_drain();

    // empty sweep
    write_reg(CFG_SERVICE_COUNT, 20'd0);
    random_phase(40, 2000);
    wait_drain();

    idle_pct = 0;
    write_all(3'd2, 20'd1000, 20'd700, 20'd8000, 4'd2, 16'd500, 4'b0101);
    random_phase(70, 800);
    wait_drain();
    write_reg(CFG_SERVICE_COUNT, 20'd1);
    random_phase(60, 1500);
    wait_drain();

    if (err_cnt == 0 && report_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/shs_pkg.sv
hw/rtl/shs_table.sv
hw/rtl/shs_exec.sv
hw/rtl/service_health_supervisor.sv
tb/tb.sv
